FILE: hdl/rsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the running statistics accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  typedef enum logic [1:0] {
    KIND_COUNT = 2'd0,
    KIND_MEAN  = 2'd1,
    KIND_SUM   = 2'd2,
    KIND_STDEV = 2'd3
  } rsa_kind_e;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } rsa_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSTART,
    ST_WDIV,
    ST_WMUL,
    ST_WACC,
    ST_MDIV,
    ST_SDIV,
    ST_SQRT
  } rsa_state_e;

  typedef struct packed {
    logic    start;
    rsa_op_e op;
  } rsa_req_t;

  localparam logic [2:0]  REG_KIND_ADDR = 3'd0;
  localparam logic        MODE_SAMPLE   = 1'b0;
  localparam logic        MODE_REPORT   = 1'b1;
  localparam logic [47:0] SUM_MAX       = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN       = 48'h8000_0000_0000;

endpackage

FILE: hdl/running_statistics_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_statistics_accumulator
// Count, sum, mean or Welford standard deviation over a reporting interval.
// ----------------------------------------------------------------------------
// Takes one word at a time. A sample for the count, mean or sum kinds, or an
// absent sample, is handled without leaving the idle state; a deviation
// sample runs through the 64-step shared divider (mean update by the count),
// then a multiply and an accumulate step. A report for count and sum needs no
// division; the mean divides the sum by the count, and the deviation divides,
// then takes the 32-step square root, all in the same shared unit. A finished
// result waits in an output register while the next word is taken; a second
// report stalls the input until that register is free.
module running_statistics_accumulator #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample_value
  input  logic [1:0]  s_tuser,   // mode, sample_present
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // result_value
  output logic [2:0]  m_tuser,   // result_not_number, result_kind[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [COUNT_BITS-1:0] CNT_CAP = '1;

  rsa_pkg::rsa_state_e state_q, state_d;
  rsa_pkg::rsa_kind_e  kind_q;
  rsa_pkg::rsa_req_t   req;

  logic [COUNT_BITS-1:0] cnt_q;
  logic signed [47:0]    sum_q, mean_q;
  logic [63:0]           sqd_q;
  logic signed [31:0]    x_q;
  logic [32:0]           dmag_q;
  logic                  dneg_q;
  logic [67:0]           term_q;
  logic                  pend_q;
  logic                  pend_nan_q, out_valid_q, out_nan_q;
  logic [47:0]           pend_data_q, out_q;
  rsa_pkg::rsa_kind_e    out_kind_q;

  logic [63:0] unit_a;
  logic        unit_done;
  logic [63:0] unit_res;

  logic accept, is_sample, present, out_load, pend_load;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic signed [48:0]    sum_add, d_full, e_full;
  logic [47:0]           sum_mag, q48, rep_data;
  logic [48:0]           d_mag, e_mag;
  logic [68:0]           sqd_add;
  logic [63:0]           cnt_ext;

  assign accept    = s_tvalid && s_tready;
  assign is_sample = s_tuser[0] == rsa_pkg::MODE_SAMPLE;
  assign present   = s_tuser[1];
  assign cnt_inc   = (cnt_q == CNT_CAP) ? cnt_q : cnt_q + COUNT_BITS'(1);
  assign sum_add   = 49'(sum_q) + 49'(signed'(s_tdata));
  assign sum_mag   = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
  assign d_full    = 49'(x_q) - 49'(mean_q);
  assign d_mag     = d_full[48] ? 49'(-d_full) : 49'(d_full);
  assign e_full    = 49'(x_q) - 49'(mean_q);
  assign e_mag     = e_full[48] ? 49'(-e_full) : 49'(e_full);
  assign q48       = dneg_q ? 48'(-unit_res[47:0]) : unit_res[47:0];
  assign sqd_add   = 69'(sqd_q) + 69'(term_q);
  assign cnt_ext   = 64'(cnt_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsa_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_sample) begin
            if (present && kind_q == rsa_pkg::KIND_STDEV) state_d = rsa_pkg::ST_WSTART;
          end else if (cnt_q != '0) begin
            if (kind_q == rsa_pkg::KIND_MEAN) state_d = rsa_pkg::ST_MDIV;
            else if (kind_q == rsa_pkg::KIND_STDEV) state_d = rsa_pkg::ST_SDIV;
          end
        end
      end
      rsa_pkg::ST_WSTART: state_d = rsa_pkg::ST_WDIV;
      rsa_pkg::ST_WDIV:   if (unit_done) state_d = rsa_pkg::ST_WMUL;
      rsa_pkg::ST_WMUL:   state_d = rsa_pkg::ST_WACC;
      rsa_pkg::ST_WACC:   state_d = rsa_pkg::ST_IDLE;
      rsa_pkg::ST_MDIV:   if (unit_done) state_d = rsa_pkg::ST_IDLE;
      rsa_pkg::ST_SDIV:   if (unit_done) state_d = rsa_pkg::ST_SQRT;
      rsa_pkg::ST_SQRT:   if (unit_done) state_d = rsa_pkg::ST_IDLE;
      default:            state_d = rsa_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req       = '{start: 1'b0, op: rsa_pkg::OP_DIV};
    unit_a    = 64'(sum_mag);
    s_tready  = 1'b0;
    pend_load = 1'b0;
    unique case (state_q)
      rsa_pkg::ST_IDLE: begin
        // a finished report waits until the output register is free
        s_tready = !pend_q;
        if (s_tvalid && !pend_q && !is_sample && cnt_q != '0) begin
          req.start = (kind_q == rsa_pkg::KIND_MEAN) || (kind_q == rsa_pkg::KIND_STDEV);
          unit_a    = (kind_q == rsa_pkg::KIND_MEAN) ? 64'(sum_mag) : sqd_q;
        end
      end
      rsa_pkg::ST_WSTART: begin
        req.start = 1'b1;
        unit_a    = 64'(d_mag);
      end
      rsa_pkg::ST_SDIV: begin
        if (unit_done) begin
          req   = '{start: 1'b1, op: rsa_pkg::OP_SQRT};
          unit_a = unit_res;
        end
      end
      rsa_pkg::ST_MDIV: pend_load = unit_done;
      rsa_pkg::ST_SQRT: pend_load = unit_done;
      default: ;
    endcase
  end

  // report value that needs no division
  always_comb begin
    unique case (kind_q)
      rsa_pkg::KIND_COUNT: begin
        rep_data = (cnt_ext > 64'(rsa_pkg::SUM_MAX)) ? rsa_pkg::SUM_MAX : cnt_ext[47:0];
      end
      rsa_pkg::KIND_SUM: rep_data = sum_q;
      default:           rep_data = '0;
    endcase
  end

  assign out_load = pend_q && (!out_valid_q || m_tready);

  rsa_divsqrt #(.COUNT_BITS(COUNT_BITS)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (unit_a),
    .b_i    (cnt_q),
    .done_o (unit_done),
    .res_o  (unit_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsa_pkg::ST_IDLE;
      kind_q      <= rsa_pkg::KIND_COUNT;
      cnt_q       <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      sqd_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready && paddr == rsa_pkg::REG_KIND_ADDR) begin
        kind_q <= rsa_pkg::rsa_kind_e'(pwdata[1:0]);
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (m_tready) out_valid_q <= 1'b0;
      if (out_load) begin
        pend_q <= 1'b0;
      end else if (pend_load || (accept && !is_sample && state_d == rsa_pkg::ST_IDLE)) begin
        pend_q <= 1'b1;
      end
      if (out_load) begin
        cnt_q  <= '0;
        sum_q  <= '0;
        mean_q <= '0;
        sqd_q  <= '0;
      end else if (accept && is_sample && present) begin
        if (kind_q != rsa_pkg::KIND_SUM) cnt_q <= cnt_inc;
        if (kind_q == rsa_pkg::KIND_MEAN || kind_q == rsa_pkg::KIND_SUM) begin
          if (!sum_add[48] && sum_add[47]) sum_q <= rsa_pkg::SUM_MAX;
          else if (sum_add[48] && !sum_add[47]) sum_q <= rsa_pkg::SUM_MIN;
          else sum_q <= sum_add[47:0];
        end
      end else if (state_q == rsa_pkg::ST_WDIV && unit_done) begin
        mean_q <= mean_q + signed'(q48);
      end else if (state_q == rsa_pkg::ST_WACC) begin
        sqd_q <= (sqd_add[68:64] != '0) ? '1 : sqd_add[63:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) x_q <= signed'(s_tdata);
    if (state_q == rsa_pkg::ST_WSTART) begin
      dmag_q <= d_mag[32:0];
      dneg_q <= d_full[48];
    end
    if (state_q == rsa_pkg::ST_WMUL) term_q <= 68'(66'(e_mag[32:0]) * 66'(dmag_q));
    if (accept && !is_sample) begin
      pend_nan_q  <= (cnt_q == '0) &&
                     (kind_q == rsa_pkg::KIND_MEAN || kind_q == rsa_pkg::KIND_STDEV);
      pend_data_q <= rep_data;
    end else if (state_q == rsa_pkg::ST_MDIV && unit_done) begin
      pend_data_q <= sum_q[47] ? 48'(-unit_res[47:0]) : unit_res[47:0];
    end else if (state_q == rsa_pkg::ST_SQRT && unit_done) begin
      pend_data_q <= unit_res[47:0];
    end
    if (out_load) begin
      out_q      <= pend_data_q;
      out_nan_q  <= pend_nan_q;
      out_kind_q <= kind_q;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_q;
  assign m_tuser  = {out_kind_q, out_nan_q};
  assign pready   = 1'b1;
  assign prdata   = (paddr == rsa_pkg::REG_KIND_ADDR) ? 32'(kind_q) : '0;

endmodule

FILE: hdl/rsa_divsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_divsqrt
// Shared restoring divider and bit-pair square root, one step per cycle.
// ----------------------------------------------------------------------------
module rsa_divsqrt #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rsa_pkg::rsa_req_t     req_i,
  input  logic [63:0]           a_i,
  input  logic [COUNT_BITS-1:0] b_i,
  output logic                  done_o,
  output logic [63:0]           res_o
);

  logic                  busy_q, done_q;
  rsa_pkg::rsa_op_e      op_q;
  logic [5:0]            cnt_q;
  logic [63:0]           acc_q;
  logic [63:0]           rem_q;
  logic [31:0]           root_q;
  logic [COUNT_BITS-1:0] b_q;

  logic [64:0] cand, sub, diff;
  logic        ge, last;

  always_comb begin
    if (op_q == rsa_pkg::OP_DIV) begin
      cand = {rem_q, acc_q[63]};
      sub  = 65'(b_q);
    end else begin
      cand = {rem_q[62:0], acc_q[63:62]};
      sub  = {31'd0, root_q, 2'b01};
    end
    ge   = cand >= sub;
    diff = cand - sub;
    last = (op_q == rsa_pkg::OP_DIV) ? (cnt_q == 6'd63) : (cnt_q == 6'd31);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q   <= req_i.op;
      cnt_q  <= '0;
      acc_q  <= a_i;
      rem_q  <= '0;
      root_q <= '0;
      b_q    <= b_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      rem_q <= ge ? diff[63:0] : cand[63:0];
      if (op_q == rsa_pkg::OP_DIV) begin
        acc_q <= {acc_q[62:0], ge};
      end else begin
        acc_q  <= {acc_q[61:0], 2'b00};
        root_q <= {root_q[30:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == rsa_pkg::OP_DIV) ? acc_q : 64'(root_q);

endmodule

FILE: hdl/rsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks for the running statistics accumulator.
// ----------------------------------------------------------------------------
module rsa_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [2:0]  m_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_sample_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && !s_tuser[0] && !m_tvalid |=> !m_tvalid)
    else $error("sample word produced a result");

  a_nan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] |-> m_tdata == 48'd0)
    else $error("not-a-number result with nonzero value");

  a_nan_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] |->
      m_tuser[2:1] == rsa_pkg::KIND_MEAN || m_tuser[2:1] == rsa_pkg::KIND_STDEV)
    else $error("not-a-number on count or sum kind");

endmodule

bind running_statistics_accumulator rsa_port_checker u_rsa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
